/* rtl/v2e_pkg.sv */
// Shared constants, item types and helpers for the vector to Euler angles block.
package v2e_pkg;

	// Number formats and chain lengths
	localparam int FRAC_BITS = 16;
	localparam int DEG_FRAC = 24;
	localparam int CORDIC_STAGES = 24;
	localparam int ISQ_STEPS = 32;
	localparam int NORM_STEPS = 6;
	localparam int CW = 44;
	localparam int ZW = 34;
	localparam int ANG_W = 25;
	localparam int MPL_W = 17;
	localparam logic [MPL_W-1:0] MPL_RESET = 17'd66;

	// Pipeline depth from accept to result strobe
	localparam int LAT = 45 + CORDIC_STAGES;
	localparam int SB_LEN = NORM_STEPS + 2 + CORDIC_STAGES;

	// Configuration word index
	localparam logic REG_MPL = 1'b0;

	// Angles in accumulator units (DEG_FRAC fraction bits)
	localparam logic signed [ZW-1:0] D90 = ZW'(64'd90 << DEG_FRAC);
	localparam logic signed [ZW-1:0] D180 = ZW'(64'd180 << DEG_FRAC);
	localparam logic signed [ZW-1:0] D270 = ZW'(64'd270 << DEG_FRAC);

	// Output rounding
	localparam int SH = DEG_FRAC - FRAC_BITS;
	localparam logic signed [ZW-1:0] RND = (SH == 0) ? '0 : ZW'(64'd1 << (SH - 1));
	localparam logic signed [ZW-1:0] FULL = ZW'(64'd360 << FRAC_BITS);

	// Arctangent of 2^-i in degrees, DEG_FRAC fraction bits, rounded
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'((64'd45000000000 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd26565051177 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd14036243468 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd7125016349 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd3576334375 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd1789910608 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd895173710 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd447614171 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd223810500 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd111905677 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd55952892 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd27976453 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd13988227 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd6994114 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd3497057 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd1748528 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd874264 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd437132 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd218566 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd109283 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd54642 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd27321 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd13660 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd6830 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd3415 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd1708 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd854 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd427 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd213 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd107 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd53 * 64'd16777216 + 64'd500000000) / 64'd1000000000),
		32'((64'd27 * 64'd16777216 + 64'd500000000) / 64'd1000000000)
	};

	typedef struct packed {
		logic signed [31:0] fwd_x;
		logic signed [31:0] fwd_y;
		logic signed [31:0] fwd_z;
		logic has_up;
		logic signed [31:0] up_x;
		logic signed [31:0] up_y;
		logic signed [31:0] up_z;
	} in_item_t;

	typedef struct packed {
		logic [ANG_W-1:0] pitch;
		logic [ANG_W-1:0] yaw;
		logic [ANG_W-1:0] roll;
	} out_item_t;

	// Square root and left-vector scaling chain
	typedef struct packed {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic has_up;
		logic vert;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] m;
		logic signed [63:0] lx;
		logic signed [63:0] ly;
		logic signed [63:0] lz;
	} sq_t;

	// Operand pair on its way to normalization
	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic [63:0] m;
	} an_t;

	// Rotation chain state
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cr_t;

	// Per-pair override of the rotation result
	typedef struct packed {
		logic [2:0] spec;
		logic [2:0][ZW-1:0] zs;
	} side_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// Round to output format and wrap into 0..360
	function automatic logic [ANG_W-1:0] to_out(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] r;
		r = (z + RND) >>> SH;
		if (r < 0) r = r + FULL;
		if (r >= FULL) r = r - FULL;
		return r[ANG_W-1:0];
	endfunction

endpackage

/* rtl/v2e_sqrt_cell.sv */
// One square-root digit step plus one scaling step of the left vector.
module v2e_sqrt_cell (
	input logic clk,
	input logic [4:0] idx,
	input v2e_pkg::sq_t d,
	output v2e_pkg::sq_t q
);

	logic [63:0] bit_w;
	logic [63:0] trial;
	v2e_pkg::sq_t nxt;

	// Try one root bit, halve left vector while its magnitude is too large
	always_comb begin
		nxt = d;
		bit_w = 64'd1 << (7'd62 - {1'b0, idx, 1'b0});
		trial = d.r + bit_w;
		if (d.v >= trial) begin
			nxt.v = d.v - trial;
			nxt.r = (d.r >> 1) + bit_w;
		end else begin
			nxt.r = d.r >> 1;
		end
		if (d.m >= 64'h0000_0000_8000_0000) begin
			nxt.m = d.m >> 1;
			nxt.lx = d.lx >>> 1;
			nxt.ly = d.ly >>> 1;
			nxt.lz = d.lz >>> 1;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

/* rtl/v2e_norm_cell.sv */
// One binary step of the operand-pair normalization into [2^39, 2^40).
module v2e_norm_cell (
	input logic clk,
	input logic [5:0] sh,
	input v2e_pkg::an_t d,
	output v2e_pkg::an_t q
);

	logic [71:0] m_ext;
	logic [71:0] hi_thr;
	logic [71:0] lo_thr;
	v2e_pkg::an_t nxt;

	// Shift down when far above the window, up when far below
	always_comb begin
		nxt = d;
		m_ext = {8'b0, d.m};
		hi_thr = 72'd1 << (7'd39 + {1'b0, sh});
		lo_thr = 72'd1 << (7'd40 - {1'b0, sh});
		if (m_ext >= hi_thr) begin
			nxt.m = d.m >> sh;
			nxt.x = d.x >>> sh;
			nxt.y = d.y >>> sh;
		end else if (m_ext < lo_thr) begin
			nxt.m = d.m << sh;
			nxt.x = d.x <<< sh;
			nxt.y = d.y <<< sh;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

/* rtl/v2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation.
module v2e_cordic_cell (
	input logic clk,
	input logic [4:0] k,
	input v2e_pkg::cr_t d,
	output v2e_pkg::cr_t q
);

	logic signed [v2e_pkg::CW-1:0] xs;
	logic signed [v2e_pkg::CW-1:0] ys;
	logic signed [v2e_pkg::ZW-1:0] az;
	v2e_pkg::cr_t nxt;

	// Rotate toward the x axis and accumulate the angle
	always_comb begin
		xs = d.x >>> k;
		ys = d.y >>> k;
		az = $signed(v2e_pkg::ZW'(v2e_pkg::ATAN_TAB[k]));
		if (d.y > 0) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + az;
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - az;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

/* rtl/vector_to_euler_angles.sv */
// Top level: forward/up vectors in, pitch, yaw and roll out, fully pipelined.
//
//  channel   handshake               payload
//  --------  ----------------------  ------------------------------------------
//  command   start / busy            item_in  (fwd_x..z, has_up, up_x..z)
//  result    done (one-cycle strobe) item_out (pitch, yaw, roll)
//  config    APB psel/penable/pready paddr, pwdata, prdata (min_planar_length)
//
// One item is taken every cycle; busy stays low. The result of an item passes through
// the 32-cell square-root chain, the 6-cell normalizer, the CORDIC rotation chain and
// seven single registers. arst_n clears the valid line and the threshold register;
// data in flight is dropped. The receiver cannot stall: each result is shown for
// exactly one cycle.
module vector_to_euler_angles (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input v2e_pkg::in_item_t item_in,
	output logic done,
	output v2e_pkg::out_item_t item_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int N = v2e_pkg::CORDIC_STAGES;

	logic accept;
	logic [v2e_pkg::MPL_W-1:0] mpl_q;
	logic [v2e_pkg::LAT-1:0] vld_q;

	v2e_pkg::in_item_t in_s1;
	v2e_pkg::in_item_t in_s2;
	logic signed [63:0] pxx_s2, pyy_s2;
	logic signed [63:0] uyfz_s2, uzfy_s2, uzfx_s2, uxfz_s2, uxfy_s2, uyfx_s2;
	v2e_pkg::sq_t sq_d3;
	v2e_pkg::sq_t sq_s3;
	v2e_pkg::sq_t sq_d [v2e_pkg::ISQ_STEPS];
	v2e_pkg::sq_t sq_c [v2e_pkg::ISQ_STEPS];
	v2e_pkg::sq_t sq_out;

	logic signed [31:0] fx_s4, fy_s4, fz_s4;
	logic has_up_s4, vert_s4, above_s4;
	logic [31:0] len_s4;
	logic signed [32:0] lx_s4, ly_s4, lz_s4;
	logic signed [32:0] lx_w, ly_w;
	logic signed [63:0] p1_s4, p2_s4;

	logic signed [63:0] upz;
	logic signed [63:0] op_x [3];
	logic signed [63:0] op_y [3];
	v2e_pkg::an_t an_d5 [3];
	v2e_pkg::an_t an_s5 [3];
	v2e_pkg::side_t sb_d;
	v2e_pkg::side_t sb_q [v2e_pkg::SB_LEN];
	v2e_pkg::an_t an_d [3][v2e_pkg::NORM_STEPS];
	v2e_pkg::an_t an_c [3][v2e_pkg::NORM_STEPS];
	v2e_pkg::cr_t cr_d6 [3];
	v2e_pkg::cr_t cr_s6 [3];
	v2e_pkg::cr_t cr_d [3][N];
	v2e_pkg::cr_t cr_c [3][N];
	logic signed [v2e_pkg::ZW-1:0] z_fin [3];
	v2e_pkg::out_item_t out_q;

	assign busy = 1'b0;
	assign accept = start & ~busy;
	assign pready = 1'b1;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpl_q <= v2e_pkg::MPL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == v2e_pkg::REG_MPL) begin
			mpl_q <= pwdata[v2e_pkg::MPL_W-1:0];
		end
	end

	assign prdata = (paddr[2] == v2e_pkg::REG_MPL) ? 32'(mpl_q) : '0;

	// Advance the valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[v2e_pkg::LAT-2:0], accept};
		end
	end

	// Capture item, then form the squares and the cross products
	always_ff @(posedge clk) begin
		in_s1 <= item_in;
		in_s2 <= in_s1;
		pxx_s2 <= in_s1.fwd_x * in_s1.fwd_x;
		pyy_s2 <= in_s1.fwd_y * in_s1.fwd_y;
		uyfz_s2 <= in_s1.up_y * in_s1.fwd_z;
		uzfy_s2 <= in_s1.up_z * in_s1.fwd_y;
		uzfx_s2 <= in_s1.up_z * in_s1.fwd_x;
		uxfz_s2 <= in_s1.up_x * in_s1.fwd_z;
		uxfy_s2 <= in_s1.up_x * in_s1.fwd_y;
		uyfx_s2 <= in_s1.up_y * in_s1.fwd_x;
	end

	// Planar square sum and left = up x forward, halved
	always_comb begin
		sq_d3.fx = in_s2.fwd_x;
		sq_d3.fy = in_s2.fwd_y;
		sq_d3.fz = in_s2.fwd_z;
		sq_d3.has_up = in_s2.has_up;
		sq_d3.vert = (in_s2.fwd_x == 0) && (in_s2.fwd_y == 0);
		sq_d3.v = $unsigned(pxx_s2) + $unsigned(pyy_s2);
		sq_d3.r = '0;
		sq_d3.lx = (uyfz_s2 >>> 1) - (uzfy_s2 >>> 1);
		sq_d3.ly = (uzfx_s2 >>> 1) - (uxfz_s2 >>> 1);
		sq_d3.lz = (uxfy_s2 >>> 1) - (uyfx_s2 >>> 1);
		sq_d3.m = v2e_pkg::mag64(sq_d3.lx);
		if (v2e_pkg::mag64(sq_d3.ly) > sq_d3.m) sq_d3.m = v2e_pkg::mag64(sq_d3.ly);
		if (v2e_pkg::mag64(sq_d3.lz) > sq_d3.m) sq_d3.m = v2e_pkg::mag64(sq_d3.lz);
	end

	always_ff @(posedge clk) begin
		sq_s3 <= sq_d3;
	end

	// Square-root chain
	for (genvar j = 0; j < v2e_pkg::ISQ_STEPS; j++) begin : g_sq
		if (j == 0) begin : g_first
			assign sq_d[j] = sq_s3;
		end else begin : g_next
			assign sq_d[j] = sq_c[j-1];
		end
		v2e_sqrt_cell u_cell (
			.clk(clk),
			.idx(5'(j)),
			.d(sq_d[j]),
			.q(sq_c[j])
		);
	end

	assign sq_out = sq_c[v2e_pkg::ISQ_STEPS-1];
	assign lx_w = sq_out.lx[32:0];
	assign ly_w = sq_out.ly[32:0];

	// Up-term products and threshold test
	always_ff @(posedge clk) begin
		fx_s4 <= sq_out.fx;
		fy_s4 <= sq_out.fy;
		fz_s4 <= sq_out.fz;
		has_up_s4 <= sq_out.has_up;
		vert_s4 <= sq_out.vert;
		len_s4 <= sq_out.r[31:0];
		lx_s4 <= lx_w;
		ly_s4 <= ly_w;
		lz_s4 <= sq_out.lz[32:0];
		p1_s4 <= sq_out.fx * ly_w;
		p2_s4 <= sq_out.fy * lx_w;
		above_s4 <= sq_out.r > 64'(mpl_q);
	end

	// Pick the three operand pairs and their exact-axis results
	always_comb begin
		upz = (p1_s4 >>> 1) - (p2_s4 >>> 1);
		op_y[0] = -64'(fz_s4);
		op_x[0] = $signed({32'b0, len_s4});
		if (!has_up_s4 || above_s4) begin
			op_y[1] = 64'(fy_s4);
			op_x[1] = 64'(fx_s4);
		end else begin
			op_y[1] = -64'(lx_s4);
			op_x[1] = 64'(ly_s4);
		end
		op_y[2] = 64'(lz_s4) <<< (v2e_pkg::FRAC_BITS - 1);
		op_x[2] = upz;
		for (int p = 0; p < 3; p++) begin
			an_d5[p].x = op_x[p];
			an_d5[p].y = op_y[p];
			an_d5[p].m = v2e_pkg::mag64(op_x[p]);
			if (v2e_pkg::mag64(op_y[p]) > an_d5[p].m) an_d5[p].m = v2e_pkg::mag64(op_y[p]);
			if (op_y[p] == 0) begin
				sb_d.spec[p] = 1'b1;
				sb_d.zs[p] = (op_x[p] < 0) ? v2e_pkg::D180 : '0;
			end else if (op_x[p] == 0) begin
				sb_d.spec[p] = 1'b1;
				sb_d.zs[p] = (op_y[p] > 0) ? v2e_pkg::D90 : -v2e_pkg::D90;
			end else begin
				sb_d.spec[p] = 1'b0;
				sb_d.zs[p] = '0;
			end
		end
		// vertical forward without up vector
		if (!has_up_s4 && vert_s4) begin
			sb_d.spec[0] = 1'b1;
			sb_d.zs[0] = (fz_s4 > 0) ? v2e_pkg::D270 : v2e_pkg::D90;
		end
		// roll only exists with up vector above threshold
		if (!(has_up_s4 && above_s4)) begin
			sb_d.spec[2] = 1'b1;
			sb_d.zs[2] = '0;
		end
	end

	always_ff @(posedge clk) begin
		an_s5 <= an_d5;
		sb_q[0] <= sb_d;
		for (int i = 1; i < v2e_pkg::SB_LEN; i++) begin
			sb_q[i] <= sb_q[i-1];
		end
	end

	// Three lanes: normalize, prerotate into the right half plane, rotate
	for (genvar p = 0; p < 3; p++) begin : g_lane
		for (genvar i = 0; i < v2e_pkg::NORM_STEPS; i++) begin : g_norm
			if (i == 0) begin : g_first
				assign an_d[p][i] = an_s5[p];
			end else begin : g_next
				assign an_d[p][i] = an_c[p][i-1];
			end
			v2e_norm_cell u_cell (
				.clk(clk),
				.sh(6'(32 >> i)),
				.d(an_d[p][i]),
				.q(an_c[p][i])
			);
		end

		always_comb begin
			cr_d6[p].x = an_c[p][v2e_pkg::NORM_STEPS-1].x[v2e_pkg::CW-1:0];
			cr_d6[p].y = an_c[p][v2e_pkg::NORM_STEPS-1].y[v2e_pkg::CW-1:0];
			cr_d6[p].z = '0;
			if (an_c[p][v2e_pkg::NORM_STEPS-1].x < 0) begin
				if (an_c[p][v2e_pkg::NORM_STEPS-1].y >= 0) begin
					cr_d6[p].x = an_c[p][v2e_pkg::NORM_STEPS-1].y[v2e_pkg::CW-1:0];
					cr_d6[p].y = -an_c[p][v2e_pkg::NORM_STEPS-1].x[v2e_pkg::CW-1:0];
					cr_d6[p].z = v2e_pkg::D90;
				end else begin
					cr_d6[p].x = -an_c[p][v2e_pkg::NORM_STEPS-1].y[v2e_pkg::CW-1:0];
					cr_d6[p].y = an_c[p][v2e_pkg::NORM_STEPS-1].x[v2e_pkg::CW-1:0];
					cr_d6[p].z = -v2e_pkg::D90;
				end
			end
		end

		always_ff @(posedge clk) begin
			cr_s6[p] <= cr_d6[p];
		end

		for (genvar j = 0; j < N; j++) begin : g_rot
			if (j == 0) begin : g_first
				assign cr_d[p][j] = cr_s6[p];
			end else begin : g_next
				assign cr_d[p][j] = cr_c[p][j-1];
			end
			v2e_cordic_cell u_cell (
				.clk(clk),
				.k(5'(j)),
				.d(cr_d[p][j]),
				.q(cr_c[p][j])
			);
		end

		assign z_fin[p] = sb_q[v2e_pkg::SB_LEN-1].spec[p] ?
			$signed(sb_q[v2e_pkg::SB_LEN-1].zs[p]) : cr_c[p][N-1].z;
	end

	// Round, wrap and present the result
	always_ff @(posedge clk) begin
		out_q.pitch <= v2e_pkg::to_out(z_fin[0]);
		out_q.yaw <= v2e_pkg::to_out(z_fin[1]);
		out_q.roll <= v2e_pkg::to_out(z_fin[2]);
	end

	assign item_out = out_q;
	assign done = vld_q[v2e_pkg::LAT-1];

endmodule

/* rtl/v2e_checker.sv */
// Port-level checks for the vector to Euler angles block, bound to the top level.
module v2e_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input v2e_pkg::in_item_t item_in,
	input logic done,
	input v2e_pkg::out_item_t item_out,
	input logic psel,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] prdata
);

	localparam logic [v2e_pkg::ANG_W-1:0] ANG_FULL = v2e_pkg::ANG_W'(v2e_pkg::FULL);

	// Every item yields its result after the fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(v2e_pkg::LAT) done)
		else $error("result missing after accepted item");

	// No result without an item
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(v2e_pkg::LAT) !done)
		else $error("result without accepted item");

	// Angles stay wrapped
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (item_out.pitch < ANG_FULL && item_out.yaw < ANG_FULL &&
			item_out.roll < ANG_FULL))
		else $error("angle outside 0 to 360");

	// Roll is zero without up vector
	a_roll: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !item_in.has_up |-> ##(v2e_pkg::LAT) item_out.roll == '0)
		else $error("roll nonzero without up vector");

	// Unmapped register words read as zero
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[2] != v2e_pkg::REG_MPL |-> prdata == '0)
		else $error("unmapped register read nonzero");

endmodule

bind vector_to_euler_angles v2e_checker u_v2e_checker (.*);

/* verif/vector_to_euler_angles_tb.sv */
// Testbench for vector_to_euler_angles: directed and random vectors checked against a predictor.
`timescale 1ns / 100ps

module vector_to_euler_angles_tb;

	localparam int WATCHDOG_LIMIT = 4 * v2e_pkg::LAT + 2000;

	// Expected angles for every accepted item, in order
	class angle_scoreboard;
		v2e_pkg::out_item_t pending_q[$];
		int errors;

		function void note_item(v2e_pkg::out_item_t exp_item);
			pending_q.push_back(exp_item);
		endfunction

		function void check_result(v2e_pkg::out_item_t got);
			v2e_pkg::out_item_t exp_item;
			if (pending_q.size() == 0) begin
				$error("result with no item pending: pitch %0d yaw %0d roll %0d",
					got.pitch, got.yaw, got.roll);
				errors++;
				return;
			end
			exp_item = pending_q.pop_front();
			if (got.pitch !== exp_item.pitch) begin
				$error("pitch expected %0d actual %0d", exp_item.pitch, got.pitch);
				errors++;
			end
			if (got.yaw !== exp_item.yaw) begin
				$error("yaw expected %0d actual %0d", exp_item.yaw, got.yaw);
				errors++;
			end
			if (got.roll !== exp_item.roll) begin
				$error("roll expected %0d actual %0d", exp_item.roll, got.roll);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	v2e_pkg::in_item_t item_in;
	logic done;
	v2e_pkg::out_item_t item_out;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	angle_scoreboard sb;
	logic [v2e_pkg::MPL_W-1:0] threshold;
	int idle_cycles;

	vector_to_euler_angles u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item_in(item_in),
		.done(done), .item_out(item_out), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Floor shift right
	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint mag_of(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// Vectoring rotation: atan2(y, x) in degrees with DEG_FRAC fraction bits
	function automatic longint angle_of(longint y, longint x);
		longint d90, m, z, t, xs, ys;
		int rs, ls;
		d90 = longint'(90) <<< v2e_pkg::DEG_FRAC;
		if (y == 0) return (x < 0) ? 2 * d90 : 0;
		if (x == 0) return (y > 0) ? d90 : -d90;
		m = (mag_of(x) > mag_of(y)) ? mag_of(x) : mag_of(y);
		rs = 0;
		ls = 0;
		while (m >= (longint'(1) << 40)) begin
			m = m >> 1;
			rs++;
		end
		while (m < (longint'(1) << 39)) begin
			m = m << 1;
			ls++;
		end
		x = floor_shr(x, rs) * (longint'(1) << ls);
		y = floor_shr(y, rs) * (longint'(1) << ls);
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = y; y = -x; x = t; z = d90;
			end else begin
				t = -y; y = x; x = t; z = -d90;
			end
		end
		for (int i = 0; i < v2e_pkg::CORDIC_STAGES; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y > 0) begin
				x += ys; y -= xs; z += longint'(v2e_pkg::ATAN_TAB[i]);
			end else begin
				x -= ys; y += xs; z -= longint'(v2e_pkg::ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic logic [v2e_pkg::ANG_W-1:0] degrees_out(longint z);
		longint r, full;
		full = longint'(360) <<< v2e_pkg::FRAC_BITS;
		r = floor_shr(z + (longint'(1) << (v2e_pkg::DEG_FRAC - v2e_pkg::FRAC_BITS - 1)),
			v2e_pkg::DEG_FRAC - v2e_pkg::FRAC_BITS);
		if (r < 0) r += full;
		if (r >= full) r -= full;
		return r[v2e_pkg::ANG_W-1:0];
	endfunction

	// Predict pitch, yaw and roll for one item
	function automatic v2e_pkg::out_item_t euler_of(v2e_pkg::in_item_t it,
		logic [v2e_pkg::MPL_W-1:0] thr);
		v2e_pkg::out_item_t o;
		longint fx, fy, fz, ux, uy, uz, lx, ly, lz, len, m, upz;
		int s;
		fx = it.fwd_x; fy = it.fwd_y; fz = it.fwd_z;
		len = int_sqrt(longint'(fx * fx) + longint'(fy * fy));
		o = '0;
		if (it.has_up) begin
			ux = it.up_x; uy = it.up_y; uz = it.up_z;
			lx = floor_shr(uy * fz, 1) - floor_shr(uz * fy, 1);
			ly = floor_shr(uz * fx, 1) - floor_shr(ux * fz, 1);
			lz = floor_shr(ux * fy, 1) - floor_shr(uy * fx, 1);
			m = mag_of(lx);
			if (mag_of(ly) > m) m = mag_of(ly);
			if (mag_of(lz) > m) m = mag_of(lz);
			s = 0;
			while (m >= (longint'(1) << 31)) begin
				m = m >> 1;
				s++;
			end
			lx = floor_shr(lx, s); ly = floor_shr(ly, s); lz = floor_shr(lz, s);
			o.pitch = degrees_out(angle_of(-fz, len));
			if (len > longint'(thr)) begin
				upz = floor_shr(fx * ly, 1) - floor_shr(fy * lx, 1);
				o.yaw = degrees_out(angle_of(fy, fx));
				o.roll = degrees_out(angle_of(lz * (longint'(1) << (v2e_pkg::FRAC_BITS - 1)),
					upz));
			end else begin
				o.yaw = degrees_out(angle_of(-lx, ly));
			end
		end else if (fx == 0 && fy == 0) begin
			o.pitch = v2e_pkg::ANG_W'((fz > 0 ? 270 : 90) << v2e_pkg::FRAC_BITS);
		end else begin
			o.pitch = degrees_out(angle_of(-fz, len));
			o.yaw = degrees_out(angle_of(fy, fx));
		end
		return o;
	endfunction

	// Check every result strobe
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(item_out);
	end

	// Count cycles with no accepted item or result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic write_threshold(logic [v2e_pkg::MPL_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * v2e_pkg::REG_MPL);
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		threshold = value;
	endtask

	// Hold the sender until all results are in, plus the pipeline tail
	task automatic drain();
		@(posedge clk);
		start <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (v2e_pkg::LAT + 4) @(posedge clk);
	endtask

	// Present one item and hold it until accepted
	task automatic send_item(v2e_pkg::in_item_t it, bit keep_start);
		start <= 1'b1;
		item_in <= it;
		do @(posedge clk); while (busy);
		sb.note_item(euler_of(it, threshold));
		if (!keep_start) start <= 1'b0;
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return 32'($signed($urandom_range(0, 200)) - 100);
			4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			6: return 32'($urandom_range(0, 60));
			default: return $urandom();
		endcase
	endfunction

	function automatic v2e_pkg::in_item_t rand_vec();
		v2e_pkg::in_item_t it;
		it.fwd_x = rand_comp();
		it.fwd_y = rand_comp();
		it.fwd_z = rand_comp();
		it.has_up = 1'($urandom_range(0, 1));
		it.up_x = rand_comp();
		it.up_y = rand_comp();
		it.up_z = rand_comp();
		// sometimes make up parallel to forward
		if ($urandom_range(0, 15) == 0) begin
			it.up_x = it.fwd_x;
			it.up_y = it.fwd_y;
			it.up_z = it.fwd_z;
		end
		return it;
	endfunction

	function automatic v2e_pkg::in_item_t make_vec(logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic hu, logic [31:0] a, logic [31:0] b, logic [31:0] c);
		v2e_pkg::in_item_t it;
		it.fwd_x = x; it.fwd_y = y; it.fwd_z = z; it.has_up = hu;
		it.up_x = a; it.up_y = b; it.up_z = c;
		return it;
	endfunction

	// Bursts of items; keep start high within a burst, and on into the next when no gap follows
	task automatic random_phase(int count);
		int burst;
		int gap;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
			for (int k = 0; k < burst && sent < count; k++) begin
				send_item(rand_vec(), ((k != burst - 1) || (gap == 0)) && (sent != count - 1));
				sent++;
			end
			repeat (gap) @(posedge clk);
		end
	endtask

	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] NEG_ONE = 32'hffff_0000;
	localparam logic [31:0] MAXV = 32'h7fff_ffff;
	localparam logic [31:0] MINV = 32'h8000_0000;

	initial begin
		sb = new();
		threshold = v2e_pkg::MPL_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		item_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: vertical, axes, degenerate left, extremes
		send_item(make_vec(0, 0, ONE, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(0, 0, NEG_ONE, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(0, 0, 0, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(ONE, 0, 0, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(NEG_ONE, 0, 0, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(0, ONE, 0, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(0, NEG_ONE, ONE, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(MAXV, MAXV, MAXV, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(MINV, MINV, MINV, 1'b0, 0, 0, 0), 1'b1);
		send_item(make_vec(ONE, 0, 0, 1'b1, 0, 0, ONE), 1'b1);
		send_item(make_vec(ONE, ONE, 0, 1'b1, 0, 0, 0), 1'b1);
		send_item(make_vec(ONE, ONE, ONE, 1'b1, ONE, ONE, ONE), 1'b1);
		send_item(make_vec(0, 0, ONE, 1'b1, ONE, 0, 0), 1'b1);
		send_item(make_vec(0, 0, NEG_ONE, 1'b1, 0, ONE, 0), 1'b1);
		send_item(make_vec(32'd66, 0, ONE, 1'b1, 0, ONE, 0), 1'b1);
		send_item(make_vec(32'd67, 0, ONE, 1'b1, 0, ONE, 0), 1'b1);
		send_item(make_vec(MINV, MINV, MINV, 1'b1, MAXV, MINV, MAXV), 1'b1);
		send_item(make_vec(MAXV, MINV, MAXV, 1'b1, MINV, MAXV, MINV), 1'b1);
		send_item(make_vec(MINV, MAXV, 0, 1'b1, MAXV, MAXV, MINV), 1'b0);
		drain();

		// Random phases over several thresholds, extremes included
		random_phase(500);
		drain();
		write_threshold(17'd0);
		random_phase(300);
		drain();
		write_threshold(17'd65536);
		send_item(make_vec(ONE, 0, ONE, 1'b1, 0, ONE, 0), 1'b1);
		send_item(make_vec(32'h0001_0001, 0, ONE, 1'b1, 0, ONE, 0), 1'b1);
		random_phase(400);
		drain();
		write_threshold(17'($urandom_range(0, 65536)));
		random_phase(500);
		drain();

		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (sb.pending_q.size() != 0) $error("%0d results never arrived", sb.pending_q.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* vector_to_euler_angles.f */
rtl/v2e_pkg.sv
rtl/v2e_sqrt_cell.sv
rtl/v2e_norm_cell.sv
rtl/v2e_cordic_cell.sv
rtl/vector_to_euler_angles.sv
rtl/v2e_checker.sv
verif/vector_to_euler_angles_tb.sv
